// ===== hdl/zpfla_pkg.sv =====
package zpfla_pkg;

  localparam int ACTION_W = 2;
  localparam int FRAME_W  = 28;
  localparam int DESC_W   = 12;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 13;
  localparam int LIMIT_W  = 29;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 29;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANY_END   = 2'd2;

  localparam logic [FRAME_W-1:0] LOW_START_RST = 28'd256;
  localparam logic [LIMIT_W-1:0] LOW_END_RST   = 29'd262144;
  localparam logic [LIMIT_W-1:0] ANY_END_RST   = 29'd268435456;

  localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd2;

  localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STS_NO_ZONE  = 3'd1;
  localparam logic [STATUS_W-1:0] STS_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] STS_NO_PAGE  = 3'd3;
  localparam logic [STATUS_W-1:0] STS_DBL_FREE = 3'd4;
  localparam logic [STATUS_W-1:0] STS_UNKNOWN  = 3'd5;

  localparam logic ZONE_LOW  = 1'b0;
  localparam logic ZONE_WIDE = 1'b1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [FRAME_W-1:0]  frame_number;
    logic                zone_request;
    logic [DESC_W-1:0]   descriptor_index;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DESC_W-1:0]   result_descriptor;
    logic [FRAME_W-1:0]  result_frame;
    logic                result_zone;
    logic [COUNT_W-1:0]  zone_free_count;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic needs_read;
    logic has_result;
  } dp_stat_t;

endpackage

// ===== hdl/zpfla_ctrl.sv =====
module zpfla_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  zpfla_pkg::dp_stat_t stat_i,
  output zpfla_pkg::dp_cmd_t  cmd_o
);
  import zpfla_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.accept = 1'b0;
    cmd_o.finish = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          if (stat_i.needs_read) begin
            state_d = ST_READ;
          end else if (stat_i.has_result) begin
            out_valid_d = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd_o.finish = 1'b1;
        out_valid_d  = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register is always free while the memory read is in flight
  a_read_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !out_valid_q)
    else $error("output busy during descriptor read");

endmodule

// ===== hdl/zpfla_dp.sv =====
module zpfla_dp #(
  parameter int NUM_PAGES = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  zpfla_pkg::dp_cmd_t                   cmd_i,
  output zpfla_pkg::dp_stat_t                  stat_o,
  input  zpfla_pkg::in_word_t                  in_word_i,
  output zpfla_pkg::out_word_t                 out_word_o,
  input  logic                                 cfg_we_i,
  input  logic [zpfla_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [zpfla_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import zpfla_pkg::*;

  localparam int IW   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int SW   = $clog2(NUM_PAGES + 1);
  localparam int CMPW = (SW > DESC_W) ? SW : DESC_W;
  localparam logic [SW-1:0] NULL_SLOT = SW'(NUM_PAGES);

  typedef struct packed {
    logic [SW-1:0]      link;
    logic               free;
    logic               zone;
    logic [FRAME_W-1:0] frame;
  } ent_t;

  ent_t           mem [NUM_PAGES];
  ent_t           rd_q;
  logic           mem_we, mem_re;
  logic [IW-1:0]  mem_waddr, mem_raddr;
  ent_t           mem_wdata;

  logic [FRAME_W-1:0] lo_start_q;
  logic [LIMIT_W-1:0] lo_end_q, any_end_q;

  logic [SW-1:0] head_q [2];
  logic [SW-1:0] head_d [2];
  logic [SW-1:0] count_q [2];
  logic [SW-1:0] count_d [2];
  logic [SW-1:0] slots_q, slots_d;

  logic          rd_free_q, rd_free_d;
  logic          zone_q, zone_d;
  logic [IW-1:0] slot_q, slot_d;
  out_word_t     out_q, out_d;

  logic               is_add, is_alloc, is_free;
  logic [LIMIT_W-1:0] frame_p1;
  logic               in_low, in_any, add_zone, table_full;
  logic               alloc_ok, alloc_zone;
  logic               free_known;
  logic               rz;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign is_add   = (in_word_i.action == ACT_ADD);
  assign is_alloc = (in_word_i.action == ACT_ALLOC);
  assign is_free  = (in_word_i.action == ACT_FREE);

  assign frame_p1   = LIMIT_W'(in_word_i.frame_number) + LIMIT_W'(1);
  assign in_low     = (in_word_i.frame_number >= lo_start_q) && (frame_p1 <= lo_end_q);
  assign in_any     = (frame_p1 <= any_end_q);
  assign add_zone   = in_low ? ZONE_LOW : ZONE_WIDE;
  assign table_full = (slots_q >= NULL_SLOT);

  always_comb begin
    alloc_ok   = 1'b0;
    alloc_zone = ZONE_LOW;
    if (in_word_i.zone_request == ZONE_WIDE && count_q[ZONE_WIDE] != '0) begin
      alloc_ok   = 1'b1;
      alloc_zone = ZONE_WIDE;
    end else if (count_q[ZONE_LOW] != '0) begin
      alloc_ok   = 1'b1;
      alloc_zone = ZONE_LOW;
    end
  end

  assign free_known = CMPW'(in_word_i.descriptor_index) < CMPW'(slots_q);

  assign stat_o.needs_read = (is_alloc && alloc_ok) || (is_free && free_known);
  assign stat_o.has_result = is_add || is_alloc || is_free;

  assign rz = rd_q.zone;

  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    slots_d   = slots_q;
    rd_free_d = rd_free_q;
    zone_d    = zone_q;
    slot_d    = slot_q;
    out_d     = out_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = '0;
    mem_raddr = '0;
    mem_wdata = '0;
    if (cmd_i.accept) begin
      unique case (in_word_i.action)
        ACT_ADD: begin
          if (table_full) begin
            out_d = '{STS_FULL, '0, '0, add_zone, COUNT_W'(count_q[add_zone])};
          end else if (!in_low && !in_any) begin
            out_d = '{STS_NO_ZONE, '0, '0, ZONE_WIDE, COUNT_W'(count_q[ZONE_WIDE])};
          end else begin
            mem_we    = 1'b1;
            mem_waddr = IW'(slots_q);
            mem_wdata = '{head_q[add_zone], 1'b1, add_zone, in_word_i.frame_number};
            head_d[add_zone]  = slots_q;
            count_d[add_zone] = count_q[add_zone] + SW'(1);
            slots_d           = slots_q + SW'(1);
            out_d = '{STS_OK, DESC_W'(slots_q), in_word_i.frame_number, add_zone,
                      COUNT_W'(count_q[add_zone] + SW'(1))};
          end
        end
        ACT_ALLOC: begin
          if (alloc_ok) begin
            mem_re    = 1'b1;
            mem_raddr = IW'(head_q[alloc_zone]);
            rd_free_d = 1'b0;
            zone_d    = alloc_zone;
            slot_d    = IW'(head_q[alloc_zone]);
          end else begin
            out_d = '{STS_NO_PAGE, '0, '0, in_word_i.zone_request,
                      COUNT_W'(count_q[in_word_i.zone_request])};
          end
        end
        ACT_FREE: begin
          if (free_known) begin
            mem_re    = 1'b1;
            mem_raddr = IW'(in_word_i.descriptor_index);
            rd_free_d = 1'b1;
            slot_d    = IW'(in_word_i.descriptor_index);
          end else begin
            out_d = '{STS_UNKNOWN, in_word_i.descriptor_index, '0, 1'b0, '0};
          end
        end
        default: ;
      endcase
    end else if (cmd_i.finish) begin
      if (!rd_free_q) begin
        mem_we    = 1'b1;
        mem_waddr = slot_q;
        mem_wdata = '{rd_q.link, 1'b0, rd_q.zone, rd_q.frame};
        head_d[zone_q]  = rd_q.link;
        count_d[zone_q] = count_q[zone_q] - SW'(1);
        out_d = '{STS_OK, DESC_W'(slot_q), rd_q.frame, rd_q.zone,
                  COUNT_W'(count_q[zone_q] - SW'(1))};
      end else if (rd_q.free) begin
        out_d = '{STS_DBL_FREE, DESC_W'(slot_q), rd_q.frame, rz, COUNT_W'(count_q[rz])};
      end else begin
        mem_we    = 1'b1;
        mem_waddr = slot_q;
        mem_wdata = '{head_q[rz], 1'b1, rz, rd_q.frame};
        head_d[rz]  = SW'(slot_q);
        count_d[rz] = count_q[rz] + SW'(1);
        out_d = '{STS_OK, DESC_W'(slot_q), rd_q.frame, rz,
                  COUNT_W'(count_q[rz] + SW'(1))};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_start_q <= LOW_START_RST;
      lo_end_q   <= LOW_END_RST;
      any_end_q  <= ANY_END_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LOW_START: lo_start_q <= FRAME_W'(cfg_data_i);
        CFG_LOW_END:   lo_end_q   <= LIMIT_W'(cfg_data_i);
        CFG_ANY_END:   any_end_q  <= LIMIT_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q[0]  <= NULL_SLOT;
      head_q[1]  <= NULL_SLOT;
      count_q[0] <= '0;
      count_q[1] <= '0;
      slots_q    <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      slots_q <= slots_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_free_q <= rd_free_d;
    zone_q    <= zone_d;
    slot_q    <= slot_d;
    out_q     <= out_d;
  end

  assign out_word_o = out_q;

  a_free_le_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((SW+1)'(count_q[0]) + (SW+1)'(count_q[1])) <= (SW+1)'(slots_q))
    else $error("free pages exceed descriptors handed out");

  a_low_head_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q[0] == NULL_SLOT) == (count_q[0] == '0))
    else $error("low zone head and count disagree");

  a_any_head_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q[1] == NULL_SLOT) == (count_q[1] == '0))
    else $error("any zone head and count disagree");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("descriptor memory read and write in one cycle");

endmodule

// ===== hdl/zoned_page_free_list_allocator.sv =====
// Zoned page-frame allocator: one LIFO free list per zone (low, any) over a
// descriptor table of NUM_PAGES entries. Add words, and every word that ends in an
// error without touching a descriptor, give their result in the next cycle;
// allocate from a non-empty list and free of a known descriptor first read the
// registered descriptor memory. One word is in work at a time; a new word is taken
// once the previous result has left or leaves in that cycle. Action code 3 is
// taken and dropped. The user is to change registers only while idle; unenforced.
module zoned_page_free_list_allocator #(
  parameter int NUM_PAGES = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  zpfla_pkg::in_word_t               in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output zpfla_pkg::out_word_t              out_word_o,
  input  logic                              cfg_we_i,
  input  logic [zpfla_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [zpfla_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import zpfla_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  zpfla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  zpfla_dp #(
    .NUM_PAGES (NUM_PAGES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_word_i   (in_word_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule
